### rtl/core/aamqa_pkg.sv
// Shared types and constants for the alpha-aware 2x2 mipmap quad averager.
package aamqa_pkg;

    localparam logic [7:0] ALPHA_MIN    = 8'd16;
    localparam int         CHANNELS     = 4;
    localparam int         COLOR_CHANS  = 3;
    localparam logic [9:0] RECIP3       = 10'd683;
    localparam int         RECIP3_SHIFT = 11;

    typedef logic [CHANNELS-1:0][7:0] t_rgba;

    typedef struct packed {
        t_rgba top_left;
        t_rgba top_right;
        t_rgba bottom_left;
        t_rgba bottom_right;
    } t_quad_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pix_out;

    typedef struct packed {
        logic [CHANNELS-1:0][8:0] upper;
        logic [CHANNELS-1:0][8:0] lower;
        logic [2:0]               used;
    } t_pair_sums;

    typedef struct packed {
        logic [COLOR_CHANS-1:0][9:0] color_sum;
        logic [7:0]                  alpha;
        logic [2:0]                  used;
    } t_quad_sums;

endpackage

### rtl/core/aamqa_reduce.sv
// First stage: pixel qualification by alpha and row-wise channel sums.
module aamqa_reduce (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  aamqa_pkg::t_quad_in   i_quad,
    input  logic                  i_ready,
    output logic                  o_ready,
    output logic                  o_valid,
    output aamqa_pkg::t_pair_sums o_sums
);

    logic                  r_valid;
    aamqa_pkg::t_pair_sums r_sums;
    aamqa_pkg::t_pair_sums n_sums;
    logic [3:0]            keep;
    aamqa_pkg::t_rgba      m_tl, m_tr, m_bl, m_br;

    always_comb begin
        keep[0] = i_quad.top_left[3]     >= aamqa_pkg::ALPHA_MIN;
        keep[1] = i_quad.top_right[3]    >= aamqa_pkg::ALPHA_MIN;
        keep[2] = i_quad.bottom_left[3]  >= aamqa_pkg::ALPHA_MIN;
        keep[3] = i_quad.bottom_right[3] >= aamqa_pkg::ALPHA_MIN;
        m_tl = keep[0] ? i_quad.top_left     : '0;
        m_tr = keep[1] ? i_quad.top_right    : '0;
        m_bl = keep[2] ? i_quad.bottom_left  : '0;
        m_br = keep[3] ? i_quad.bottom_right : '0;
        for (int k = 0; k < aamqa_pkg::CHANNELS; k++) begin
            n_sums.upper[k] = {1'b0, m_tl[k]} + {1'b0, m_tr[k]};
            n_sums.lower[k] = {1'b0, m_bl[k]} + {1'b0, m_br[k]};
        end
        n_sums.used = 3'({2'b0, keep[0]} + {2'b0, keep[1]})
                    + 3'({2'b0, keep[2]} + {2'b0, keep[3]});
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sums <= n_sums;
        end
    end

    assign o_valid = r_valid;
    assign o_sums  = r_sums;

endmodule

### rtl/core/aamqa_accum.sv
// Second stage: full quad sums and the quarter-scaled alpha.
module aamqa_accum (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  aamqa_pkg::t_pair_sums i_sums,
    input  logic                  i_ready,
    output logic                  o_ready,
    output logic                  o_valid,
    output aamqa_pkg::t_quad_sums o_sums
);

    logic                  r_valid;
    aamqa_pkg::t_quad_sums r_sums;
    aamqa_pkg::t_quad_sums n_sums;
    logic [9:0]            alpha_sum;

    always_comb begin
        for (int k = 0; k < aamqa_pkg::COLOR_CHANS; k++) begin
            n_sums.color_sum[k] = {1'b0, i_sums.upper[k]} + {1'b0, i_sums.lower[k]};
        end
        alpha_sum    = {1'b0, i_sums.upper[aamqa_pkg::CHANNELS-1]}
                     + {1'b0, i_sums.lower[aamqa_pkg::CHANNELS-1]};
        n_sums.alpha = alpha_sum[9:2];
        n_sums.used  = i_sums.used;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sums <= n_sums;
        end
    end

    assign o_valid = r_valid;
    assign o_sums  = r_sums;

endmodule

### rtl/core/aamqa_divide.sv
// Third stage: division of the color sums by the pixel count, into the output register.
module aamqa_divide (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  aamqa_pkg::t_quad_sums i_sums,
    input  logic                  i_ready,
    output logic                  o_ready,
    output logic                  o_valid,
    output aamqa_pkg::t_pix_out   o_pix
);

    logic                                    r_valid;
    aamqa_pkg::t_pix_out                     r_pix;
    aamqa_pkg::t_pix_out                     n_pix;
    logic [aamqa_pkg::COLOR_CHANS-1:0][7:0]  quot;
    logic [aamqa_pkg::COLOR_CHANS-1:0][19:0] prod;

    always_comb begin
        for (int k = 0; k < aamqa_pkg::COLOR_CHANS; k++) begin
            prod[k] = {10'b0, i_sums.color_sum[k]} * {10'b0, aamqa_pkg::RECIP3};
            case (i_sums.used)
                3'd1: quot[k] = i_sums.color_sum[k][7:0];
                3'd2: quot[k] = i_sums.color_sum[k][8:1];
                3'd3: quot[k] = prod[k][aamqa_pkg::RECIP3_SHIFT +: 8];
                3'd4: quot[k] = i_sums.color_sum[k][9:2];
                default: quot[k] = 8'd0;
            endcase
        end
        n_pix.red   = quot[0];
        n_pix.green = quot[1];
        n_pix.blue  = quot[2];
        n_pix.alpha = i_sums.alpha;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pix <= n_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

### rtl/core/alpha_aware_mipmap_quad_average.sv
// Top level of the alpha-aware 2x2 mipmap quad averager.
//
//   Channel  Direction  Payload                 Handshake
//   quad     in         i_quad (4 x RGBA8)      i_valid / o_stall
//   pixel    out        o_pix  (RGBA8)          o_valid / i_stall
//
// One quad per cycle is accepted while o_stall is low.
// Each result passes through three register stages: qualify, sum, divide.
// Synchronous active-low reset empties all stages.
// A stall only stops stages that are full, so bubbles are squeezed out and nothing is lost.
module alpha_aware_mipmap_quad_average (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  aamqa_pkg::t_quad_in i_quad,
    output logic                o_stall,
    output logic                o_valid,
    output aamqa_pkg::t_pix_out o_pix,
    input  logic                i_stall
);

    logic                  s1_valid, s1_ready;
    logic                  s2_valid, s2_ready;
    logic                  s3_ready;
    aamqa_pkg::t_pair_sums s1_sums;
    aamqa_pkg::t_quad_sums s2_sums;

    aamqa_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_quad  (i_quad),
        .i_ready (s2_ready),
        .o_ready (s1_ready),
        .o_valid (s1_valid),
        .o_sums  (s1_sums)
    );

    aamqa_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_sums  (s1_sums),
        .i_ready (s3_ready),
        .o_ready (s2_ready),
        .o_valid (s2_valid),
        .o_sums  (s2_sums)
    );

    aamqa_divide u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .i_sums  (s2_sums),
        .i_ready (!i_stall),
        .o_ready (s3_ready),
        .o_valid (o_valid),
        .o_pix   (o_pix)
    );

    assign o_stall = !s1_ready;

`ifndef SYNTH
    a_accept_fills_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> s1_valid)
        else $error("accepted quad did not reach the first stage");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> s1_valid && s2_valid && o_valid && i_stall)
        else $error("input stalled while the pipeline has room");

    a_output_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !s2_valid |=> !o_valid)
        else $error("output transfer repeated a result");
`endif

endmodule

### test/testbench.sv
// Self-checking testbench for the alpha-aware 2x2 mipmap quad averager.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_QUADS = 1650;
    localparam int CALM_TAIL    = 150;
    localparam int LONG_HOLD_AT = 400;
    localparam int LONG_HOLD    = 120;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE       = 12;
    localparam int REPORT_MAX   = 10;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    aamqa_pkg::t_quad_in i_quad  = '0;
    logic                i_stall = 1'b0;
    logic                o_stall;
    logic                o_valid;
    aamqa_pkg::t_pix_out o_pix;

    aamqa_pkg::t_quad_in quad_backlog[$];
    aamqa_pkg::t_pix_out pixel_expected[$];
    int                  quads_sent     = 0;
    int                  mismatch_count = 0;
    int                  send_gap       = 0;
    int                  hold_cnt       = 0;
    int                  idle_cycles    = 0;
    logic                long_hold_done = 1'b0;
    logic                calm           = 1'b0;

    alpha_aware_mipmap_quad_average dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_quad  (i_quad),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_pix   (o_pix),
        .i_stall (i_stall)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic aamqa_pkg::t_rgba px(input int r, input int g, input int b,
                                            input int a);
        aamqa_pkg::t_rgba p;
        p[0] = r[7:0];
        p[1] = g[7:0];
        p[2] = b[7:0];
        p[3] = a[7:0];
        return p;
    endfunction

    function automatic aamqa_pkg::t_quad_in quad_of(input aamqa_pkg::t_rgba tl,
                                                    input aamqa_pkg::t_rgba tr,
                                                    input aamqa_pkg::t_rgba bl,
                                                    input aamqa_pkg::t_rgba br);
        aamqa_pkg::t_quad_in q;
        q.top_left     = tl;
        q.top_right    = tr;
        q.bottom_left  = bl;
        q.bottom_right = br;
        return q;
    endfunction

    function automatic aamqa_pkg::t_pix_out mip_average(input aamqa_pkg::t_quad_in q);
        aamqa_pkg::t_rgba    pix[4];
        int                  sum[aamqa_pkg::CHANNELS];
        int                  counted;
        aamqa_pkg::t_pix_out res;
        pix[0] = q.top_left;
        pix[1] = q.top_right;
        pix[2] = q.bottom_left;
        pix[3] = q.bottom_right;
        counted = 0;
        for (int k = 0; k < aamqa_pkg::CHANNELS; k++) sum[k] = 0;
        for (int p = 0; p < 4; p++) begin
            if (pix[p][3] >= aamqa_pkg::ALPHA_MIN) begin
                for (int k = 0; k < aamqa_pkg::CHANNELS; k++) sum[k] += pix[p][k];
                counted++;
            end
        end
        res.red   = (counted == 0) ? 8'd0 : 8'(sum[0] / counted);
        res.green = (counted == 0) ? 8'd0 : 8'(sum[1] / counted);
        res.blue  = (counted == 0) ? 8'd0 : 8'(sum[2] / counted);
        res.alpha = 8'(sum[3] / 4);
        return res;
    endfunction

    function automatic aamqa_pkg::t_rgba rand_pixel();
        int c[3];
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 3))
                0: c[k] = 0;
                1: c[k] = 255;
                default: c[k] = $urandom_range(0, 255);
            endcase
        end
        case ($urandom_range(0, 5))
            0: return aamqa_pkg::t_rgba'($urandom());
            1: return px(c[0], c[1], c[2], $urandom_range(0, 15));
            2: return px(c[0], c[1], c[2], $urandom_range(14, 18));
            3: return px(c[0], c[1], c[2], 255);
            default: return px(c[0], c[1], c[2], $urandom_range(16, 255));
        endcase
    endfunction

    always @(posedge i_clk) begin : drive
        logic                nxt_valid;
        aamqa_pkg::t_quad_in nxt_quad;
        int                  nxt_gap;
        nxt_valid = i_valid;
        nxt_quad  = i_quad;
        nxt_gap   = send_gap;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                pixel_expected.push_back(mip_average(i_quad));
                quads_sent <= quads_sent + 1;
                nxt_valid = 1'b0;
            end
            if (!(i_valid && o_stall)) begin
                if (nxt_gap > 0) begin
                    nxt_valid = 1'b0;
                    nxt_gap--;
                end else if (quad_backlog.size() > 0) begin
                    nxt_quad  = quad_backlog.pop_front();
                    nxt_valid = 1'b1;
                    if (!calm && $urandom_range(0, 9) == 0) nxt_gap = $urandom_range(1, 7);
                end
            end
        end
        i_valid  <= nxt_valid;
        i_quad   <= nxt_quad;
        send_gap <= nxt_gap;
        calm     <= (quad_backlog.size() < CALM_TAIL);
    end

    always @(posedge i_clk) begin : receive
        logic nxt_stall;
        nxt_stall = 1'b0;
        if (i_rst_n) begin
            if (!long_hold_done && quads_sent >= LONG_HOLD_AT) begin
                hold_cnt       = LONG_HOLD;
                long_hold_done = 1'b1;
            end else if (hold_cnt == 0 && !calm && $urandom_range(0, 7) == 0) begin
                hold_cnt = $urandom_range(1, 7);
            end
            if (hold_cnt > 0) begin
                nxt_stall = 1'b1;
                hold_cnt--;
            end
        end
        i_stall <= nxt_stall;
    end

    always @(posedge i_clk) begin : check
        aamqa_pkg::t_pix_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixel_expected.size() == 0) begin
                if (mismatch_count < REPORT_MAX)
                    $display("Unexpected pixel transfer: %h", o_pix);
                mismatch_count++;
            end else begin
                want = pixel_expected.pop_front();
                if (o_pix.red !== want.red || o_pix.green !== want.green ||
                    o_pix.blue !== want.blue || o_pix.alpha !== want.alpha) begin
                    if (mismatch_count < REPORT_MAX)
                        $display(
                            "Pixel mismatch: expected r=%h g=%h b=%h a=%h, got r=%h g=%h b=%h a=%h",
                                 want.red, want.green, want.blue, want.alpha,
                                 o_pix.red, o_pix.green, o_pix.blue, o_pix.alpha);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout with no transfer for %0d cycles", idle_cycles);
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        quad_backlog.push_back(quad_of(px(0, 0, 0, 0), px(0, 0, 0, 0),
                                       px(0, 0, 0, 0), px(0, 0, 0, 0)));
        quad_backlog.push_back(quad_of(px(255, 255, 255, 255), px(255, 255, 255, 255),
                                       px(255, 255, 255, 255), px(255, 255, 255, 255)));
        quad_backlog.push_back(quad_of(px(255, 255, 255, 15), px(255, 255, 255, 15),
                                       px(255, 255, 255, 15), px(255, 255, 255, 15)));
        quad_backlog.push_back(quad_of(px(255, 0, 128, 16), px(0, 255, 1, 16),
                                       px(3, 7, 255, 16), px(254, 1, 0, 16)));
        quad_backlog.push_back(quad_of(px(200, 100, 50, 16), px(255, 255, 255, 15),
                                       px(255, 255, 255, 0), px(255, 255, 255, 15)));
        quad_backlog.push_back(quad_of(px(255, 255, 255, 15), px(17, 34, 51, 255),
                                       px(255, 255, 255, 15), px(255, 255, 255, 0)));
        quad_backlog.push_back(quad_of(px(255, 255, 255, 0), px(255, 255, 255, 15),
                                       px(9, 250, 77, 128), px(255, 255, 255, 15)));
        quad_backlog.push_back(quad_of(px(255, 255, 255, 15), px(255, 255, 255, 15),
                                       px(255, 255, 255, 15), px(255, 0, 255, 17)));
        quad_backlog.push_back(quad_of(px(255, 255, 255, 255), px(0, 0, 0, 16),
                                       px(255, 255, 255, 14), px(0, 0, 0, 0)));
        quad_backlog.push_back(quad_of(px(255, 255, 2, 255), px(255, 254, 0, 255),
                                       px(254, 255, 0, 255), px(255, 255, 255, 15)));
        quad_backlog.push_back(quad_of(px(1, 128, 0, 16), px(1, 128, 0, 17),
                                       px(0, 129, 1, 18), px(0, 0, 0, 0)));
        quad_backlog.push_back(quad_of(px(255, 255, 255, 15), px(85, 170, 3, 200),
                                       px(86, 171, 4, 100), px(86, 171, 5, 50)));
        quad_backlog.push_back(quad_of(px(100, 101, 102, 16), px(100, 101, 102, 255),
                                       px(255, 255, 255, 14), px(101, 100, 99, 33)));
        quad_backlog.push_back(quad_of(px(254, 253, 252, 255), px(255, 255, 255, 255),
                                       px(255, 255, 255, 254), px(251, 250, 1, 255)));
        quad_backlog.push_back(quad_of(px(10, 20, 30, 15), px(40, 50, 60, 16),
                                       px(70, 80, 90, 17), px(100, 110, 120, 255)));
        quad_backlog.push_back(quad_of(px(0, 0, 0, 16), px(0, 0, 0, 16),
                                       px(0, 0, 0, 16), px(0, 0, 0, 16)));
        quad_backlog.push_back(quad_of(px(255, 255, 255, 255), px(0, 0, 0, 0),
                                       px(0, 0, 0, 0), px(0, 0, 0, 0)));
        quad_backlog.push_back(quad_of(px(0, 0, 0, 255), px(255, 255, 255, 255),
                                       px(255, 255, 255, 255), px(255, 255, 255, 255)));
        quad_backlog.push_back(quad_of(px(255, 255, 255, 15), px(0, 0, 0, 255),
                                       px(0, 0, 0, 255), px(1, 1, 1, 255)));
        for (int n = 0; n < RANDOM_QUADS; n++)
            quad_backlog.push_back(quad_of(rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel()));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (quad_backlog.size() != 0 || i_valid || pixel_expected.size() != 0);
        repeat (SETTLE) @(posedge i_clk);

        if (mismatch_count == 0 && pixel_expected.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
